### rtl/core/gde_pkg.sv
// ----------------------------------------------------------------------------
// gde_pkg: shared definitions for the Gaussian detection efficiency block
// Widths, register indexes, pipeline control structs and the exp(-t) tables.
// ----------------------------------------------------------------------------
package gde_pkg;

  // Coordinate and table sizing.
  localparam int COORD_WIDTH     = 24;
  localparam int EXP_TABLE_DEPTH = 256;

  // Signed difference of two coordinates always fits in 33 bits.
  localparam int D_W    = 33;
  // Clamped per-axis term: 0 .. 16.0 in Q.32, i.e. up to 2^36.
  localparam int TERM_W = 37;
  // Sum of three clamped terms.
  localparam int SUM_W  = 39;
  // Table index and the width that holds the depth itself.
  localparam int IDX_W  = $clog2(EXP_TABLE_DEPTH);
  localparam int DEP_W  = $clog2(EXP_TABLE_DEPTH + 1);

  localparam int EFF_W  = 16;
  localparam int GAIN_W = 16;
  localparam int CFG_W  = 32;
  localparam int CFG_IDX_W = 3;

  // Pipeline depth: five lane stages and four merge stages.
  localparam int NSTG = 9;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X = 3'd0,
    REG_OFFSET_Y = 3'd1,
    REG_OFFSET_Z = 3'd2,
    REG_COEF_X   = 3'd3,
    REG_COEF_Y   = 3'd4,
    REG_COEF_Z   = 3'd5,
    REG_GAIN     = 3'd6
  } cfg_reg_t;

  // Stage load enables for one lane.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } lane_ctl_t;

  // Stage load enables for the merge unit.
  typedef struct packed {
    logic s6;
    logic s7;
    logic s8;
    logic s9;
  } merge_ctl_t;

  typedef logic [31:0] exp_tab_t [EXP_TABLE_DEPTH];

  // Builds the sampled exp(-t) curve in Q1.31 with step 16/DEPTH.
  // With upper clear it returns points 0..DEPTH-1, with upper set 1..DEPTH.
  function automatic exp_tab_t exp_table(input logic upper);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    logic [63:0]        e;
    exp_tab_t           tab;
    x    = (64'd1 << 35) / EXP_TABLE_DEPTH;
    term = 64'd1 << 31;
    sum  = 64'sd1 <<< 31;
    // Taylor series of exp(-x) for one step.
    for (int n = 1; n <= 21; n++) begin
      term = ((term * x) >> 31) / 64'(n);
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = $unsigned(sum);
    if (r > (64'd1 << 31)) begin
      r = 64'd1 << 31;
    end
    // Repeated multiplication by one step, rounded.
    e = 64'd1 << 31;
    if (!upper) begin
      tab[0] = e[31:0];
    end
    for (int k = 1; k <= EXP_TABLE_DEPTH; k++) begin
      e = (e * r + (64'd1 << 30)) >> 31;
      if (upper) begin
        tab[k-1] = e[31:0];
      end else if (k < EXP_TABLE_DEPTH) begin
        tab[k] = e[31:0];
      end
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_LO = exp_table(1'b0);
  localparam exp_tab_t EXP_HI = exp_table(1'b1);

endpackage

### rtl/core/gaussian_3d_efficiency.sv
// ----------------------------------------------------------------------------
// gaussian_3d_efficiency: Gaussian detection efficiency of a 3D position
// Three axis lanes and a merge unit form peak_gain * exp(-sum of terms).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one position beat with the
//   coordinates in_pos_x/y/z in nanometres. The result channel
//   (out_valid/out_ready) returns one beat with out_detect_eff in Q1.15.
//   The configuration channel (cfg_valid/cfg_ready) writes register
//   cfg_index with cfg_data; it is always ready and should be used only
//   while no beat is in flight. Unknown indexes are ignored.
//   A position passes the nine stage registers in order to the result beat.
//   One beat is taken per cycle while the receiver takes results: each stage
//   holds one position and loads the next one as its own moves on.
//   When the receiver stalls, beats move up into empty stages; in_ready
//   drops only when every stage holds a beat and the output is not taken.
//   Synchronous reset empties the pipeline and loads the register defaults
//   (offsets 0, coefficients 858993, peak gain 1.0). No clearing pass.
// ----------------------------------------------------------------------------
module gaussian_3d_efficiency
  import gde_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [EFF_W-1:0]              out_detect_eff,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  logic signed [COORD_WIDTH-1:0] off_x_r;
  logic signed [COORD_WIDTH-1:0] off_y_r;
  logic signed [COORD_WIDTH-1:0] off_z_r;
  logic [31:0]                   coef_x_r;
  logic [31:0]                   coef_y_r;
  logic [31:0]                   coef_z_r;
  logic [GAIN_W-1:0]             gain_r;

  logic [NSTG:1]     vld_r;
  logic [NSTG:1]     vld_nxt;
  logic [NSTG+1:1]   rdy;
  lane_ctl_t         lane_ctl;
  merge_ctl_t        merge_ctl;
  logic [TERM_W-1:0] term_x;
  logic [TERM_W-1:0] term_y;
  logic [TERM_W-1:0] term_z;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r  <= '0;
      off_y_r  <= '0;
      off_z_r  <= '0;
      coef_x_r <= 32'd858993;
      coef_y_r <= 32'd858993;
      coef_z_r <= 32'd858993;
      gain_r   <= GAIN_W'(32768);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OFFSET_X: off_x_r  <= cfg_data[COORD_WIDTH-1:0];
        REG_OFFSET_Y: off_y_r  <= cfg_data[COORD_WIDTH-1:0];
        REG_OFFSET_Z: off_z_r  <= cfg_data[COORD_WIDTH-1:0];
        REG_COEF_X:   coef_x_r <= cfg_data;
        REG_COEF_Y:   coef_y_r <= cfg_data;
        REG_COEF_Z:   coef_z_r <= cfg_data;
        REG_GAIN:     gain_r   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    rdy[NSTG+1] = out_ready;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_nxt[1] = rdy[1] ? in_valid : vld_r[1];
    for (int k = 2; k <= NSTG; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = vld_r[NSTG];

  assign lane_ctl.s1  = rdy[1];
  assign lane_ctl.s2  = rdy[2];
  assign lane_ctl.s3  = rdy[3];
  assign lane_ctl.s4  = rdy[4];
  assign lane_ctl.s5  = rdy[5];
  assign merge_ctl.s6 = rdy[6];
  assign merge_ctl.s7 = rdy[7];
  assign merge_ctl.s8 = rdy[8];
  assign merge_ctl.s9 = rdy[9];

  // One lane per axis.
  gde_lane u_lane_x (
    .clk  (clk),
    .ctl  (lane_ctl),
    .pos  (in_pos_x),
    .off  (off_x_r),
    .coef (coef_x_r),
    .term (term_x)
  );

  gde_lane u_lane_y (
    .clk  (clk),
    .ctl  (lane_ctl),
    .pos  (in_pos_y),
    .off  (off_y_r),
    .coef (coef_y_r),
    .term (term_y)
  );

  gde_lane u_lane_z (
    .clk  (clk),
    .ctl  (lane_ctl),
    .pos  (in_pos_z),
    .off  (off_z_r),
    .coef (coef_z_r),
    .term (term_z)
  );

  // Sum, exponential and gain.
  gde_merge u_merge (
    .clk    (clk),
    .ctl    (merge_ctl),
    .term_x (term_x),
    .term_y (term_y),
    .term_z (term_z),
    .gain   (gain_r),
    .eff    (out_detect_eff)
  );

`ifndef SYNTH
  // With no result waiting, the whole pipeline can move, so input is taken.
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low while output stage is empty");

  // A full pipeline with a stalled receiver must not take another beat.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ((&vld_r) && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline is full and stalled");

  // Occupancy changes by at most one beat per cycle.
  a_occupancy_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (($countones(vld_r) <= $countones($past(vld_r)) + 1) &&
                      ($countones(vld_r) + 1 >= $countones($past(vld_r)))))
    else $error("pipeline occupancy jumped");
`endif

endmodule

### rtl/core/gde_lane.sv
// ----------------------------------------------------------------------------
// gde_lane: one axis of the exponent
// Computes min(|pos - offset|^2 * coef, 16.0) in Q.32 over five stages.
// ----------------------------------------------------------------------------
module gde_lane
  import gde_pkg::*;
(
  input  logic                          clk,
  input  lane_ctl_t                     ctl,
  input  logic signed [COORD_WIDTH-1:0] pos,
  input  logic signed [COORD_WIDTH-1:0] off,
  input  logic [31:0]                   coef,
  output logic [TERM_W-1:0]             term
);

  logic signed [D_W-1:0] pos_ext;
  logic signed [D_W-1:0] off_ext;
  logic signed [D_W-1:0] diff;
  logic [D_W-1:0]        abs_nxt;
  logic                  coef_nz;

  logic [D_W-1:0]    abs_r;
  logic [63:0]       sq_r;
  logic              sat2_r;
  logic [31:0]       sq_hi_r;
  logic [63:0]       plo3_r;
  logic              sat3_r;
  logic [63:0]       plo4_r;
  logic [63:0]       phi4_r;
  logic              sat4_r;
  logic [TERM_W-1:0] term_nxt;
  logic [TERM_W-1:0] term_r;

  assign coef_nz = (coef != 32'd0);

  // Stage 1: signed distance and its magnitude.
  assign pos_ext = {{(D_W-COORD_WIDTH){pos[COORD_WIDTH-1]}}, pos};
  assign off_ext = {{(D_W-COORD_WIDTH){off[COORD_WIDTH-1]}}, off};
  assign diff    = pos_ext - off_ext;
  assign abs_nxt = diff[D_W-1] ? $unsigned(-diff) : $unsigned(diff);

  always_ff @(posedge clk) begin
    if (ctl.s1) begin
      abs_r <= abs_nxt;
    end
  end

  // Stage 2: square of the distance; a distance beyond 32 bits saturates.
  always_ff @(posedge clk) begin
    if (ctl.s2) begin
      sq_r   <= 64'(abs_r[31:0]) * 64'(abs_r[31:0]);
      sat2_r <= abs_r[D_W-1] && coef_nz;
    end
  end

  // Stage 3: low half of the square times the coefficient.
  always_ff @(posedge clk) begin
    if (ctl.s3) begin
      plo3_r  <= 64'(sq_r[31:0]) * 64'(coef);
      sq_hi_r <= sq_r[63:32];
      sat3_r  <= sat2_r;
    end
  end

  // Stage 4: high half of the square times the coefficient.
  always_ff @(posedge clk) begin
    if (ctl.s4) begin
      phi4_r <= 64'(sq_hi_r) * 64'(coef);
      plo4_r <= plo3_r;
      sat4_r <= sat3_r;
    end
  end

  // Stage 5: combine the halves and clamp at 16.0.
  always_comb begin
    term_nxt = TERM_W'(phi4_r[3:0]) << 32;
    term_nxt = term_nxt + TERM_W'(plo4_r[35:0]);
    if (sat4_r || (phi4_r >= 64'd16) || (plo4_r[63:36] != '0) || term_nxt[TERM_W-1]) begin
      term_nxt = TERM_W'(1) << 36;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s5) begin
      term_r <= term_nxt;
    end
  end

  assign term = term_r;

endmodule

### rtl/core/gde_merge.sv
// ----------------------------------------------------------------------------
// gde_merge: exponent sum, exp(-t) lookup and gain
// Adds the three lane terms, interpolates exp(-t) from the table and scales.
// ----------------------------------------------------------------------------
module gde_merge
  import gde_pkg::*;
(
  input  logic              clk,
  input  merge_ctl_t        ctl,
  input  logic [TERM_W-1:0] term_x,
  input  logic [TERM_W-1:0] term_y,
  input  logic [TERM_W-1:0] term_z,
  input  logic [GAIN_W-1:0] gain,
  output logic [EFF_W-1:0]  eff
);

  logic [SUM_W-1:0]    t_sum;
  logic                sat_nxt;
  logic [36+DEP_W-1:0] pos_scaled;
  logic [DEP_W-1:0]    idx_full;
  logic [IDX_W-1:0]    idx_nxt;
  logic [31:0]         frac_nxt;

  logic [IDX_W-1:0] idx6_r;
  logic [31:0]      frac6_r;
  logic             sat6_r;
  logic [31:0]      e0_r;
  logic [31:0]      e1_r;
  logic [31:0]      frac7_r;
  logic             sat7_r;
  logic [31:0]      diff8;
  logic [63:0]      corr8;
  logic [31:0]      v8_r;
  logic             sat8_r;
  logic [47:0]      scaled9;
  logic [EFF_W-1:0] eff_r;

  // Stage 6: total exponent, saturation and table position.
  assign t_sum      = SUM_W'(term_x) + SUM_W'(term_y) + SUM_W'(term_z);
  assign sat_nxt    = (t_sum[SUM_W-1:36] != '0);
  assign pos_scaled = (36+DEP_W)'(t_sum[35:0]) * (36+DEP_W)'(EXP_TABLE_DEPTH);
  assign idx_full   = pos_scaled[36+DEP_W-1:36];

  always_comb begin
    if (idx_full >= DEP_W'(EXP_TABLE_DEPTH)) begin
      idx_nxt  = IDX_W'(EXP_TABLE_DEPTH - 1);
      frac_nxt = '1;
    end else begin
      idx_nxt  = idx_full[IDX_W-1:0];
      frac_nxt = pos_scaled[35:4];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s6) begin
      idx6_r  <= idx_nxt;
      frac6_r <= frac_nxt;
      sat6_r  <= sat_nxt;
    end
  end

  // Stage 7: the two neighboring table points.
  always_ff @(posedge clk) begin
    if (ctl.s7) begin
      e0_r    <= EXP_LO[idx6_r];
      e1_r    <= EXP_HI[idx6_r];
      frac7_r <= frac6_r;
      sat7_r  <= sat6_r;
    end
  end

  // Stage 8: linear interpolation between the points.
  assign diff8 = (e1_r <= e0_r) ? (e0_r - e1_r) : 32'd0;
  assign corr8 = 64'(diff8) * 64'(frac7_r);

  always_ff @(posedge clk) begin
    if (ctl.s8) begin
      v8_r   <= e0_r - corr8[63:32];
      sat8_r <= sat7_r;
    end
  end

  // Stage 9: amplitude scaling with rounding, zero on saturation; output register.
  assign scaled9 = 48'(v8_r) * 48'(gain) + (48'd1 << 30);

  always_ff @(posedge clk) begin
    if (ctl.s9) begin
      eff_r <= sat8_r ? '0 : scaled9[31+EFF_W-1:31];
    end
  end

  assign eff = eff_r;

endmodule

### tb/tb_gaussian_3d_efficiency.sv
// ----------------------------------------------------------------------------
// tb_gaussian_3d_efficiency: self-checking bench for the 3D Gaussian efficiency
// A queue-fed driver sends positions and register writes. A monitor predicts
// peak_gain * exp(-t) from its own table and checks each result beat in order.
// ----------------------------------------------------------------------------
module tb_gaussian_3d_efficiency;
  import gde_pkg::*;

  // Index with no register behind it. Writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam logic [63:0] T_SAT = 64'd1 << 36;
  localparam logic [63:0] ONE_Q31 = 64'd1 << 31;
  localparam int unsigned SETTLE_CYCLES = NSTG + 3;
  localparam int unsigned LONG_HOLD = 300;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 117;

  typedef enum logic [1:0] {PLAN_POS, PLAN_WRITE, PLAN_PAUSE} plan_kind_t;

  typedef struct {
    plan_kind_t             kind;
    logic [COORD_WIDTH-1:0] px;
    logic [COORD_WIDTH-1:0] py;
    logic [COORD_WIDTH-1:0] pz;
    logic [CFG_IDX_W-1:0]   wr_index;
    logic [CFG_W-1:0]       wr_data;
    int unsigned            gap;
  } plan_item_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [COORD_WIDTH-1:0] in_pos_x = '0;
  logic signed [COORD_WIDTH-1:0] in_pos_y = '0;
  logic signed [COORD_WIDTH-1:0] in_pos_z = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [EFF_W-1:0]              out_detect_eff;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_W-1:0]              cfg_data = '0;

  // Stimulus plan and the expected efficiencies still owed by the block.
  plan_item_t       plan_q[$];
  logic [EFF_W-1:0] eff_expected_q[$];

  // Sampled exp(-t) curve in Q1.31, one point per step of 16/DEPTH.
  logic [63:0] exp_curve [EXP_TABLE_DEPTH+1];

  // Predictor copy of the registers.
  logic [COORD_WIDTH-1:0] prd_off_x, prd_off_y, prd_off_z;
  logic [31:0]            prd_coef_x, prd_coef_y, prd_coef_z;
  logic [GAIN_W-1:0]      prd_gain;

  // Offsets as planned, used to aim positions near the detection center.
  logic [COORD_WIDTH-1:0] plan_off_x = '0;
  logic [COORD_WIDTH-1:0] plan_off_y = '0;
  logic [COORD_WIDTH-1:0] plan_off_z = '0;

  int          accepted_cnt = 0;
  int          received_cnt = 0;
  int          error_count = 0;
  int          planned_pos = 0;
  int          hold_trigger = 0;
  int unsigned gap_left = 0;
  int unsigned settle_cnt = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  gaussian_3d_efficiency DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_detect_eff (out_detect_eff),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Squared distance on one axis times its coefficient, Q.32, clamped to 16.0.
  function automatic logic [63:0] axis_exponent(input logic [COORD_WIDTH-1:0] pos,
                                                input logic [COORD_WIDTH-1:0] off,
                                                input logic [31:0] coef);
    logic signed [63:0] pos_s;
    logic signed [63:0] off_s;
    logic signed [63:0] delta;
    logic [63:0]        mag;
    logic [63:0]        sq;
    logic [63:0]        hi;
    logic [63:0]        lo;
    pos_s = $signed(pos);
    off_s = $signed(off);
    delta = pos_s - off_s;
    mag = (delta < 0) ? -delta : delta;
    if (coef == 32'd0) return 64'd0;
    if (mag > 64'hFFFF_FFFF) return T_SAT;
    sq = mag * mag;
    hi = (sq >> 32) * coef;
    lo = {32'd0, sq[31:0]} * coef;
    if (hi >= 64'd16 || lo >= T_SAT) return T_SAT;
    hi = (hi << 32) + lo;
    return (hi >= T_SAT) ? T_SAT : hi;
  endfunction

  // Expected efficiency of one position under the current registers.
  function automatic logic [EFF_W-1:0] efficiency_of(input logic [COORD_WIDTH-1:0] px,
                                                     input logic [COORD_WIDTH-1:0] py,
                                                     input logic [COORD_WIDTH-1:0] pz);
    logic [63:0] expo;
    logic [63:0] scaled;
    logic [63:0] idx;
    logic [63:0] frac;
    logic [63:0] val;
    logic [63:0] eff;
    expo = axis_exponent(px, prd_off_x, prd_coef_x)
         + axis_exponent(py, prd_off_y, prd_coef_y)
         + axis_exponent(pz, prd_off_z, prd_coef_z);
    if (expo >= T_SAT) return '0;
    scaled = (expo * 64'(EXP_TABLE_DEPTH)) >> 4;
    idx = scaled >> 32;
    frac = {32'd0, scaled[31:0]};
    if (idx >= 64'(EXP_TABLE_DEPTH)) begin
      idx = 64'(EXP_TABLE_DEPTH - 1);
      frac = 64'hFFFF_FFFF;
    end
    val = exp_curve[idx];
    // Linear interpolation toward the next sample.
    if (exp_curve[idx+1] <= val) begin
      val = val - (((val - exp_curve[idx+1]) * frac) >> 32);
    end
    eff = (val * {48'd0, prd_gain} + (64'd1 << 30)) >> 31;
    return eff[EFF_W-1:0];
  endfunction

  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [CFG_W-1:0] rand_offset();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    // Upper bits carry junk that the block must drop.
    if (roll < 10) return {8'($urandom()), 24'h80_0000};
    if (roll < 20) return {8'($urandom()), 24'h7F_FFFF};
    return $urandom();
  endfunction

  function automatic logic [CFG_W-1:0] rand_coef();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 32'd0;
    if (roll < 20) return 32'hFFFF_FFFF;
    if (roll < 30) return 32'd858993;
    return $urandom() >> $urandom_range(0, 31);
  endfunction

  function automatic logic [CFG_W-1:0] rand_gain();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return {16'($urandom()), 16'd0};
    if (roll < 20) return {16'($urandom()), 16'hFFFF};
    if (roll < 30) return {16'($urandom()), 16'h8000};
    return $urandom();
  endfunction

  // A coordinate at a random distance from the center, of random magnitude.
  function automatic logic [COORD_WIDTH-1:0] near_center(input logic [COORD_WIDTH-1:0] off);
    logic [COORD_WIDTH-1:0] mag;
    mag = COORD_WIDTH'($urandom_range(0, 1 << $urandom_range(0, 22)));
    return ($urandom_range(0, 1) != 0) ? off + mag : off - mag;
  endfunction

  task automatic plan_position(input logic [COORD_WIDTH-1:0] px,
                               input logic [COORD_WIDTH-1:0] py,
                               input logic [COORD_WIDTH-1:0] pz,
                               input int unsigned gap);
    plan_item_t it;
    it.kind = PLAN_POS;
    it.px = px;
    it.py = py;
    it.pz = pz;
    it.wr_index = '0;
    it.wr_data = '0;
    it.gap = gap;
    plan_q.push_back(it);
    planned_pos++;
  endtask

  task automatic plan_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    plan_item_t it;
    it.kind = PLAN_WRITE;
    it.px = '0;
    it.py = '0;
    it.pz = '0;
    it.wr_index = idx;
    it.wr_data = data;
    it.gap = idle_len() % 4;
    plan_q.push_back(it);
    case (idx)
      REG_OFFSET_X: plan_off_x = data[COORD_WIDTH-1:0];
      REG_OFFSET_Y: plan_off_y = data[COORD_WIDTH-1:0];
      REG_OFFSET_Z: plan_off_z = data[COORD_WIDTH-1:0];
      default: ;
    endcase
  endtask

  // The sender stops until every result is back and the pipeline is empty.
  task automatic plan_pause();
    plan_item_t it;
    it.kind = PLAN_PAUSE;
    it.px = '0;
    it.py = '0;
    it.pz = '0;
    it.wr_index = '0;
    it.wr_data = '0;
    it.gap = 0;
    plan_q.push_back(it);
  endtask

  // Driver: offers the head of the plan and holds it until the beat is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left <= 0;
      settle_cnt <= 0;
    end else if ((in_valid && !in_ready) || (cfg_valid && !cfg_ready)) begin
      // Beat still on offer.
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (plan_q.size() == 0) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      case (plan_q[0].kind)
        PLAN_POS: begin
          in_valid <= 1'b1;
          cfg_valid <= 1'b0;
          in_pos_x <= plan_q[0].px;
          in_pos_y <= plan_q[0].py;
          in_pos_z <= plan_q[0].pz;
          gap_left <= plan_q[0].gap;
          plan_q.delete(0);
        end
        PLAN_WRITE: begin
          in_valid <= 1'b0;
          cfg_valid <= 1'b1;
          cfg_index <= plan_q[0].wr_index;
          cfg_data <= plan_q[0].wr_data;
          gap_left <= plan_q[0].gap;
          plan_q.delete(0);
        end
        default: begin
          in_valid <= 1'b0;
          cfg_valid <= 1'b0;
          if (!in_valid && !cfg_valid && accepted_cnt == received_cnt) begin
            if (settle_cnt == SETTLE_CYCLES) begin
              settle_cnt <= 0;
              plan_q.delete(0);
            end else begin
              settle_cnt <= settle_cnt + 1;
            end
          end else begin
            settle_cnt <= 0;
          end
        end
      endcase
    end
  end

  // Receiver: random stalls, a quiet stretch now and then, and one long hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_cnt >= hold_trigger) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= ((received_cnt / 64) % 4 == 1) ? 0 : idle_len();
    end
  end

  // Monitor: tracks register writes, predicts on input beats, checks results.
  always @(posedge clk) begin : monitor
    logic [EFF_W-1:0] want;
    if (!rst_n) begin
      prd_off_x = '0;
      prd_off_y = '0;
      prd_off_z = '0;
      prd_coef_x = 32'd858993;
      prd_coef_y = 32'd858993;
      prd_coef_z = 32'd858993;
      prd_gain = 16'h8000;
      accepted_cnt <= 0;
      received_cnt <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OFFSET_X: prd_off_x = cfg_data[COORD_WIDTH-1:0];
          REG_OFFSET_Y: prd_off_y = cfg_data[COORD_WIDTH-1:0];
          REG_OFFSET_Z: prd_off_z = cfg_data[COORD_WIDTH-1:0];
          REG_COEF_X:   prd_coef_x = cfg_data;
          REG_COEF_Y:   prd_coef_y = cfg_data;
          REG_COEF_Z:   prd_coef_z = cfg_data;
          REG_GAIN:     prd_gain = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        eff_expected_q.push_back(efficiency_of(in_pos_x, in_pos_y, in_pos_z));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (out_valid && out_ready) begin
        if (eff_expected_q.size() == 0) begin
          $error("detect_eff beat with nothing expected: actual %0d", out_detect_eff);
          error_count++;
        end else begin
          want = eff_expected_q.pop_front();
          if (out_detect_eff !== want) begin
            $error("detect_eff mismatch: expected %0d, actual %0d", want, out_detect_eff);
            error_count++;
          end
        end
        received_cnt <= received_cnt + 1;
      end
    end
  end

  // Stimulus plan, reset and end of run.
  initial begin : stimulus
    logic [63:0]        step;
    logic [63:0]        term;
    logic [63:0]        ratio;
    logic signed [63:0] series;
    logic               quiet;
    logic               leftover;
    int                 wait_cnt;

    // exp(-step) by its Taylor series, then repeated rounded products.
    step = (64'd1 << 35) / 64'(EXP_TABLE_DEPTH);
    term = ONE_Q31;
    series = $signed(ONE_Q31);
    for (int n = 1; n <= 21; n++) begin
      term = ((term * step) >> 31) / 64'(n);
      if (n % 2 == 1) begin
        series = series - $signed(term);
      end else begin
        series = series + $signed(term);
      end
    end
    if (series < 0) begin
      series = 0;
    end
    ratio = $unsigned(series);
    if (ratio > ONE_Q31) begin
      ratio = ONE_Q31;
    end
    exp_curve[0] = ONE_Q31;
    for (int k = 1; k <= EXP_TABLE_DEPTH; k++) begin
      exp_curve[k] = (exp_curve[k-1] * ratio + (64'd1 << 30)) >> 31;
    end

    // Reset defaults: the center, moderate distances and saturating extremes.
    plan_position(24'd0, 24'd0, 24'd0, 0);
    plan_position(24'd100, 24'd0, 24'd0, 0);
    plan_position(24'd0, -24'd100, 24'd50, 1);
    plan_position(24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 0);
    plan_position(24'h80_0000, 24'h80_0000, 24'h80_0000, 2);
    plan_position(24'd1, -24'd1, 24'd1, 0);

    // Zero coefficients leave only the gain, here above one.
    plan_pause();
    plan_write(REG_COEF_X, 32'd0);
    plan_write(REG_COEF_Y, 32'd0);
    plan_write(REG_COEF_Z, 32'd0);
    plan_write(REG_GAIN, 32'hFFFF_FFFF);
    plan_write(REG_NONE, 32'hFFFF_FFFF);
    plan_position(24'h7F_FFFF, 24'h80_0000, 24'd0, 0);
    plan_position(24'h80_0000, 24'h7F_FFFF, 24'd1234, 0);

    // Extreme offsets with junk upper bits, largest and smallest coefficients.
    plan_pause();
    plan_write(REG_OFFSET_X, 32'hFF80_0000);
    plan_write(REG_OFFSET_Y, 32'h007F_FFFF);
    plan_write(REG_OFFSET_Z, 32'hABCD_0010);
    plan_write(REG_COEF_X, 32'hFFFF_FFFF);
    plan_write(REG_COEF_Y, 32'd1);
    plan_write(REG_COEF_Z, 32'd858993);
    plan_write(REG_GAIN, 32'd12345);
    // Full-scale distance on x saturates.
    plan_position(24'h7F_FFFF, plan_off_y, plan_off_z, 0);
    plan_position(plan_off_x, plan_off_y, plan_off_z, 0);
    plan_position(plan_off_x + 24'd1, plan_off_y + 24'd1000, plan_off_z, 0);
    plan_position(plan_off_x, plan_off_y - 24'd65536, plan_off_z, 0);
    plan_position(plan_off_x, 24'h80_0000, plan_off_z, 0);
    // Exponent just under 16 uses the last table segment; one step more saturates.
    plan_position(plan_off_x + 24'd4, plan_off_y, plan_off_z, 0);
    plan_position(plan_off_x + 24'd5, plan_off_y, plan_off_z, 0);

    // Zero gain.
    plan_pause();
    plan_write(REG_OFFSET_X, 32'd0);
    plan_write(REG_OFFSET_Y, 32'd0);
    plan_write(REG_OFFSET_Z, 32'd0);
    plan_write(REG_COEF_X, 32'd858993);
    plan_write(REG_GAIN, 32'd0);
    plan_position(24'd0, 24'd0, 24'd0, 0);
    plan_position(24'd50, 24'd50, 24'd50, 0);

    // Random phases, each under freshly drawn registers.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      plan_pause();
      plan_write(REG_OFFSET_X, rand_offset());
      plan_write(REG_OFFSET_Y, rand_offset());
      plan_write(REG_OFFSET_Z, rand_offset());
      plan_write(REG_COEF_X, rand_coef());
      plan_write(REG_COEF_Y, rand_coef());
      plan_write(REG_COEF_Z, rand_coef());
      plan_write(REG_GAIN, rand_gain());
      if ($urandom_range(0, 1) != 0) begin
        plan_write(REG_NONE, $urandom());
      end
      quiet = (ph == 0 || ph == 2 || ph == 5);
      // The long receiver hold lands while the sender streams back to back.
      if (ph == 2) begin
        hold_trigger = planned_pos + 6;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 85) begin
          plan_position(near_center(plan_off_x), near_center(plan_off_y),
                        near_center(plan_off_z), quiet ? 0 : idle_len());
        end else begin
          plan_position(COORD_WIDTH'($urandom()), COORD_WIDTH'($urandom()),
                        COORD_WIDTH'($urandom()), quiet ? 0 : idle_len());
        end
      end
    end
    plan_pause();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (plan_q.size() != 0) @(posedge clk);
    wait_cnt = 0;
    while (accepted_cnt != received_cnt && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (NSTG + 4) @(posedge clk);
    @(negedge clk);
    leftover = (eff_expected_q.size() != 0);
    if (leftover) begin
      $error("%0d detect_eff results never arrived", eff_expected_q.size());
    end
    if (error_count == 0 && !leftover) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### gaussian_3d_efficiency.f
rtl/core/gde_pkg.sv
rtl/core/gde_lane.sv
rtl/core/gde_merge.sv
rtl/core/gaussian_3d_efficiency.sv
tb/tb_gaussian_3d_efficiency.sv
